@@ hdl/bwm_pkg.sv @@
// Shared types and constants for the EMS bank window mapper.
`timescale 1ns / 1ps
package bwm_pkg;

    localparam int KB_W    = 12;
    localparam int PORT_W  = 16;
    localparam int ADDR_W  = 20;
    localparam int DATA_W  = 8;
    localparam int PHYS_W  = 21;
    localparam int KIND_W  = 2;
    localparam int NWIN    = 4;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PORT_RD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PORT_WR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_XLATE   = 2'd2;

    // configuration register indexes
    localparam logic CFG_INSTALLED_KB = 1'b0;
    localparam logic CFG_MODEL        = 1'b1;

    // port decode within each 16 KB port block
    localparam logic [13:0] PORT_PAGE = 14'h208;
    localparam logic [13:0] PORT_CTRL = 14'h209;

    localparam logic [KB_W-1:0]   KB_RESET    = 12'd640;
    localparam logic [KB_W-1:0]   KB_PORTS_ON = 12'd640;
    localparam logic [DATA_W-1:0] PAGE_RESET  = 8'h7F;
    localparam logic [DATA_W-1:0] UNMAPPED_RD = 8'hFF;

    localparam logic [PHYS_W-1:0] BASE_ORIG  = 21'h70000;
    localparam logic [PHYS_W-1:0] BASE_THIRD = 21'h30000;
    localparam logic [7:0]        KB_ADD_ORIG  = 8'd64;
    localparam logic [8:0]        KB_ADD_THIRD = 9'd320;

    typedef logic [NWIN-1:0][DATA_W-1:0] t_regbank;

    typedef struct packed {
        logic              hit;
        logic [PHYS_W-1:0] phys;
        logic              in_range;
    } t_xlate;

endpackage

@@ hdl/bwm_regs.sv @@
// Page and control register bank with I/O port decode.
`timescale 1ns / 1ps
module bwm_regs
    import bwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_commit,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [PORT_W-1:0] i_port,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [KB_W-1:0]   i_installed_kb,
    output logic [DATA_W-1:0] o_read_data,
    output t_regbank          o_pages,
    output logic [NWIN-1:0]   o_base_select
);

    t_regbank    r_page;
    t_regbank    r_ctrl;
    logic        live;
    logic [1:0]  idx;
    logic [13:0] low;
    logic        hit_page;
    logic        hit_ctrl;

    assign live     = i_installed_kb > KB_PORTS_ON;
    assign idx      = i_port[15:14];
    assign low      = i_port[13:0];
    assign hit_page = live && (low == PORT_PAGE);
    assign hit_ctrl = live && (low == PORT_CTRL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NWIN; i++) begin
                r_page[i] <= PAGE_RESET;
                r_ctrl[i] <= (i == NWIN - 1) ? 8'h00 : 8'h80;
            end
        end else if (i_commit && (i_kind == KIND_PORT_WR)) begin
            if (hit_page) begin
                r_page[idx] <= i_write_data;
            end else if (hit_ctrl) begin
                r_ctrl[idx] <= i_write_data;
            end
        end
    end

    always_comb begin
        o_read_data = '0;
        if (i_kind == KIND_PORT_RD) begin
            if (hit_page) begin
                o_read_data = r_page[idx];
            end else if (hit_ctrl) begin
                o_read_data = r_ctrl[idx];
            end else begin
                o_read_data = UNMAPPED_RD;
            end
        end
    end

    // base select is bit 7 of each control register, so derive it directly
    always_comb begin
        for (int i = 0; i < NWIN; i++) begin
            o_base_select[i] = r_ctrl[i][7];
        end
    end

    assign o_pages = r_page;

endmodule

@@ hdl/bwm_xlate.sv @@
// Window hit test and physical address translation.
`timescale 1ns / 1ps
module bwm_xlate
    import bwm_pkg::*;
(
    input  logic              i_enable,
    input  logic [ADDR_W-1:0] i_cpu_address,
    input  t_regbank          i_pages,
    input  logic [NWIN-1:0]   i_base_select,
    input  logic [KB_W-1:0]   i_installed_kb,
    input  logic              i_model_variant,
    output t_xlate            o_xlate
);

    logic [1:0]        win;
    logic [DATA_W-1:0] pg;
    logic [3:0]        sel_sum;
    logic [7:0]        kb_orig;
    logic [8:0]        kb_third;
    logic [PHYS_W-1:0] base;
    logic [PHYS_W-1:0] phys;
    logic              hit;

    assign win     = i_cpu_address[15:14];
    assign pg      = i_pages[win];
    assign sel_sum = i_base_select + 4'd4 - {2'b00, win};

    // window lies in the C/D/E/F segments, placed by bits 3:2 of base select + 4 - window index
    assign hit = i_enable && pg[7] && (i_cpu_address[19:18] == 2'b11)
               && (i_cpu_address[17:16] == sel_sum[3:2]);

    assign kb_orig  = i_installed_kb[7:0] + KB_ADD_ORIG;
    assign kb_third = i_installed_kb[8:0] + KB_ADD_THIRD;

    always_comb begin
        if (i_model_variant) begin
            base = BASE_THIRD + PHYS_W'({kb_third, 10'b0});
        end else begin
            base = BASE_ORIG + PHYS_W'({kb_orig, 10'b0});
        end
    end

    assign phys = base + PHYS_W'({pg[3:0], 14'b0}) + PHYS_W'({pg[6], 18'b0})
                + PHYS_W'(i_cpu_address[13:0]);

    always_comb begin
        o_xlate = '0;
        if (hit) begin
            o_xlate.hit      = 1'b1;
            o_xlate.phys     = phys;
            o_xlate.in_range = {1'b0, phys} < {i_installed_kb, 10'b0};
        end
    end

endmodule

@@ hdl/ems_bank_window_mapper.sv @@
// Top level of the EMS bank window mapper: input stage, register bank, result stage.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------------------
//  in      | to block  | i_in_valid / o_in_stall     | kind, port, cpu_address, write_data
//  out     | from block| o_out_valid / i_out_stall   | read_data, window_hit, phys_address, in_range
//  cfg     | to block  | i_cfg_we                    | i_cfg_index, i_cfg_data
//
// One word per cycle unless the result stalls; words pass the input, then the result register.
// Register writes take effect as the word moves into the result register, so the next word
// sees them. Reset is synchronous, active low; page and control registers return to defaults.
// A stalled result holds; the input register still takes a word while it is empty or while
// the result register is free or being emptied.
`timescale 1ns / 1ps
module ems_bank_window_mapper
    import bwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [KB_W-1:0]   i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [PORT_W-1:0] i_port,
    input  logic [ADDR_W-1:0] i_cpu_address,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_window_hit,
    output logic [PHYS_W-1:0] o_phys_address,
    output logic              o_in_range
);

    logic [KB_W-1:0]   r_installed_kb;
    logic              r_model_variant;

    logic              r_s1_valid;
    logic [KIND_W-1:0] r_kind;
    logic [PORT_W-1:0] r_port;
    logic [ADDR_W-1:0] r_cpu_address;
    logic [DATA_W-1:0] r_write_data;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;
    t_xlate            r_xl;

    logic              advance;
    logic              commit;
    logic [DATA_W-1:0] rd;
    t_regbank          pages;
    logic [NWIN-1:0]   bsel;
    t_xlate            xl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_installed_kb  <= KB_RESET;
            r_model_variant <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INSTALLED_KB: r_installed_kb  <= i_cfg_data;
                CFG_MODEL:        r_model_variant <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign advance    = !r_out_valid || !i_out_stall;
    assign commit     = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_kind        <= i_kind;
            r_port        <= i_port;
            r_cpu_address <= i_cpu_address;
            r_write_data  <= i_write_data;
        end
    end

    bwm_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_commit       (commit),
        .i_kind         (r_kind),
        .i_port         (r_port),
        .i_write_data   (r_write_data),
        .i_installed_kb (r_installed_kb),
        .o_read_data    (rd),
        .o_pages        (pages),
        .o_base_select  (bsel)
    );

    bwm_xlate u_xlate (
        .i_enable        (r_kind == KIND_XLATE),
        .i_cpu_address   (r_cpu_address),
        .i_pages         (pages),
        .i_base_select   (bsel),
        .i_installed_kb  (r_installed_kb),
        .i_model_variant (r_model_variant),
        .o_xlate         (xl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_read_data <= rd;
            r_xl        <= xl;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_window_hit   = r_xl.hit;
    assign o_phys_address = r_xl.phys;
    assign o_in_range     = r_xl.in_range;

endmodule

@@ hdl/bwm_checker.sv @@
// Port-level checks for the EMS bank window mapper, bound to the top level.
`timescale 1ns / 1ps
module bwm_checker
    import bwm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DATA_W-1:0] o_read_data,
    input logic              o_window_hit,
    input logic [PHYS_W-1:0] o_phys_address,
    input logic              o_in_range
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_phys_address)
            && $stable(o_read_data) && $stable(o_window_hit))
        else $error("stalled result word changed");

    // the input side stalls only behind a stalled full result register
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_window_hit |-> o_phys_address == '0 && !o_in_range)
        else $error("translation fields set without a window hit");

    a_hit_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_window_hit |-> o_read_data == '0)
        else $error("read data on a translate word");

endmodule

bind ems_bank_window_mapper bwm_checker u_bwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_read_data    (o_read_data),
    .o_window_hit   (o_window_hit),
    .o_phys_address (o_phys_address),
    .o_in_range     (o_in_range)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the EMS bank window mapper: directed, random and back-pressure runs.
`timescale 1ns / 1ps
module tb_top;
    import bwm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int                DRAIN_CYCLES = 6;
    localparam int                HOLD_CYCLES  = 400;
    localparam int                QUIET_LIMIT  = 4000;
    localparam int                PRINT_LIMIT  = 30;
    localparam logic [31:0]       WIN_ORIGIN   = 32'hC0000;
    localparam logic [31:0]       WIN_SPAN     = 32'h4000;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              window_hit;
        logic [PHYS_W-1:0] phys_address;
        logic              in_range;
    } t_mapper_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [KB_W-1:0]   i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [KIND_W-1:0] i_kind;
    logic [PORT_W-1:0] i_port;
    logic [ADDR_W-1:0] i_cpu_address;
    logic [DATA_W-1:0] i_write_data;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [DATA_W-1:0] o_read_data;
    logic              o_window_hit;
    logic [PHYS_W-1:0] o_phys_address;
    logic              o_in_range;

    // shadow of the mapper state
    logic [DATA_W-1:0] page_reg [NWIN];
    logic [DATA_W-1:0] ctrl_reg [NWIN];
    logic [3:0]        base_sel;
    logic [KB_W-1:0]   kb_setting;
    logic              model_setting;

    t_mapper_word awaited_words [$];
    t_pace        pace = PACE_FREE;
    logic         pressure_req = 1'b0;
    int           hold_left = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    ems_bank_window_mapper u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_port         (i_port),
        .i_cpu_address  (i_cpu_address),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_window_hit   (o_window_hit),
        .o_phys_address (o_phys_address),
        .o_in_range     (o_in_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void reset_mapper_state();
        for (int i = 0; i < NWIN; i++) begin
            page_reg[i] = PAGE_RESET;
            ctrl_reg[i] = (i == NWIN - 1) ? 8'h00 : 8'h80;
        end
        base_sel      = 4'd7;
        kb_setting    = KB_RESET;
        model_setting = 1'b0;
    endfunction

    // Work out the response to one word and advance the shadow state.
    function automatic t_mapper_word mapper_response(input logic [KIND_W-1:0] kind,
                                                     input logic [PORT_W-1:0] port,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic [DATA_W-1:0] data);
        t_mapper_word r;
        logic [1:0]   idx;
        logic [1:0]   win;
        logic [13:0]  low;
        logic [3:0]   sel;
        logic [31:0]  start;
        logic [31:0]  base;
        logic [31:0]  phys;
        logic [31:0]  kb32;
        logic [31:0]  pg;
        r    = '0;
        idx  = port[15:14];
        low  = port[13:0];
        kb32 = {20'd0, kb_setting};
        case (kind)
            KIND_PORT_RD: begin
                r.read_data = UNMAPPED_RD;
                if (kb_setting > KB_PORTS_ON) begin
                    if (low == PORT_PAGE)
                        r.read_data = page_reg[idx];
                    else if (low == PORT_CTRL)
                        r.read_data = ctrl_reg[idx];
                end
            end
            KIND_PORT_WR: begin
                if (kb_setting > KB_PORTS_ON) begin
                    if (low == PORT_PAGE) begin
                        page_reg[idx] = data;
                    end else if (low == PORT_CTRL) begin
                        ctrl_reg[idx] = data;
                        for (int i = 0; i < NWIN; i++)
                            base_sel[i] = ctrl_reg[i][7];
                    end
                end
            end
            KIND_XLATE: begin
                win   = addr[15:14];
                // only bits 3:2 matter, so 4-bit wrap-around is harmless
                sel   = (base_sel + 4'd4 - {2'b00, win}) & 4'hC;
                start = WIN_ORIGIN + ({30'd0, win} << 14) + ({28'd0, sel} << 14);
                if (page_reg[win][7] && {12'd0, addr} >= start &&
                        {12'd0, addr} < start + WIN_SPAN) begin
                    if (model_setting)
                        base = 32'h30000 + (((kb32 + 32'd320) & 32'd511) << 10);
                    else
                        base = 32'h70000 + (((kb32 + 32'd64) & 32'd255) << 10);
                    pg             = {24'd0, page_reg[win]};
                    phys           = base + ((pg & 32'h0F) << 14) + ((pg & 32'h40) << 12)
                                   + {18'd0, addr[13:0]};
                    phys           = phys & 32'h1FFFFF;
                    r.window_hit   = 1'b1;
                    r.phys_address = phys[PHYS_W-1:0];
                    r.in_range     = (phys < (kb32 << 10));
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (mismatches < PRINT_LIMIT)
            $display("tb: MISMATCH at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        mismatches++;
    endtask

    function automatic logic sender_idles();
        case (pace)
            PACE_SEND_IDLE: return $urandom_range(0, 99) < 86;
            PACE_BOTH:      return $urandom_range(0, 99) < 20;
            default:        return 1'b0;
        endcase
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [PORT_W-1:0] port,
                             input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        while (sender_idles()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_port        <= port;
        i_cpu_address <= addr;
        i_write_data  <= data;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        awaited_words.push_back(mapper_response(kind, port, addr, data));
    endtask

    task automatic send_random_word();
        logic [KIND_W-1:0] kind;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [1:0]        blk;
        int                roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            kind = KIND_PORT_RD;
        else if (roll < 60)
            kind = KIND_PORT_WR;
        else if (roll < 98)
            kind = KIND_XLATE;
        else
            kind = KIND_UNUSED;
        blk  = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 9);
        if (roll == 0)
            port = PORT_W'($urandom);
        else if (roll == 1)
            port = {blk, PORT_PAGE ^ (14'd1 << $urandom_range(0, 13))};
        else
            port = {blk, ($urandom_range(0, 1) != 0) ? PORT_PAGE : PORT_CTRL};
        addr = ADDR_W'($urandom);
        // keep most translations inside the window area
        if ($urandom_range(0, 9) < 8)
            addr[19:18] = 2'b11;
        data = DATA_W'($urandom);
        send_word(kind, port, addr, data);
    endtask

    // Drop valid and let the pipeline run empty.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic index, input logic [KB_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_INSTALLED_KB)
            kb_setting = value;
        else
            model_setting = value[0];
    endtask

    // Reset state with 640 KB: ports dead, every window disabled.
    task automatic test_small_memory();
        pace = PACE_FREE;
        send_word(KIND_PORT_RD, 16'h0208, '0, '0);
        send_word(KIND_PORT_RD, 16'hC209, '0, '0);
        send_word(KIND_PORT_WR, 16'h0208, '0, 8'hFF);
        send_word(KIND_XLATE,   16'h0000, 20'hC0000, '0);
        send_word(KIND_XLATE,   16'h0000, 20'hE0000, '0);
        send_word(KIND_UNUSED,  16'h0208, 20'hFFFFF, 8'hFF);
    endtask

    task automatic test_register_map();
        write_cfg(CFG_INSTALLED_KB, 12'd4095);
        write_cfg(CFG_MODEL, 12'd1);
        send_word(KIND_PORT_RD, 16'h0208, '0, '0);
        send_word(KIND_PORT_RD, 16'h4209, '0, '0);
        send_word(KIND_PORT_RD, 16'hC209, '0, '0);
        send_word(KIND_PORT_WR, 16'h0208, '0, 8'h80);
        send_word(KIND_PORT_WR, 16'h4208, '0, 8'hFF);
        send_word(KIND_PORT_WR, 16'h8208, '0, 8'hCF);
        send_word(KIND_PORT_WR, 16'hC208, '0, 8'h00);
        send_word(KIND_XLATE, '0, 20'hE0000, '0);
        send_word(KIND_XLATE, '0, 20'hE3FFF, '0);
        send_word(KIND_XLATE, '0, 20'hE4000, '0);
        send_word(KIND_XLATE, '0, 20'hC0000, '0);
        send_word(KIND_XLATE, '0, 20'hFFFFF, '0);
        send_word(KIND_XLATE, '0, 20'h00000, '0);
        // move window 0 down to the bottom of the area
        send_word(KIND_PORT_WR, 16'hC209, '0, 8'h80);
        send_word(KIND_XLATE,   '0, 20'hC0000, '0);
        send_word(KIND_PORT_WR, 16'h0209, '0, 8'h00);
        send_word(KIND_PORT_RD, 16'h020A, '0, '0);
        send_word(KIND_PORT_WR, 16'h0207, '0, 8'h55);
        send_word(KIND_PORT_RD, 16'hFFFF, '0, '0);
        send_word(KIND_PORT_RD, 16'h8208, '0, '0);
        send_word(KIND_PORT_RD, 16'h0209, '0, '0);
        write_cfg(CFG_MODEL, 12'd0);
        send_word(KIND_XLATE, '0, 20'hC4000, '0);
    endtask

    task automatic test_random_traffic(input logic [KB_W-1:0] kb, input logic model,
                                       input t_pace p, input int count);
        write_cfg(CFG_INSTALLED_KB, kb);
        write_cfg(CFG_MODEL, {11'd0, model});
        pace = p;
        repeat (count) send_random_word();
    endtask

    // Hold the result side off while words keep coming, so the input stalls.
    task automatic test_backpressure();
        write_cfg(CFG_INSTALLED_KB, 12'd3000);
        write_cfg(CFG_MODEL, 12'd0);
        pace         = PACE_FREE;
        pressure_req = 1'b1;
        repeat (80) send_random_word();
    endtask

    always @(posedge i_clk) begin
        if (pressure_req) begin
            hold_left    = HOLD_CYCLES;
            pressure_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (pace)
                PACE_RECV_STALL: i_out_stall <= ($urandom_range(0, 99) < 86);
                PACE_BOTH:       i_out_stall <= ($urandom_range(0, 99) < 20);
                default:         i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_mapper_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_words.size() == 0) begin
                report_mismatch("word with nothing awaited", 0, 0);
            end else begin
                want = awaited_words.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", 32'(want.read_data), 32'(o_read_data));
                if (o_window_hit !== want.window_hit)
                    report_mismatch("window_hit", 32'(want.window_hit), 32'(o_window_hit));
                if (o_phys_address !== want.phys_address)
                    report_mismatch("phys_address", 32'(want.phys_address),
                                    32'(o_phys_address));
                if (o_in_range !== want.in_range)
                    report_mismatch("in_range", 32'(want.in_range), 32'(o_in_range));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_INSTALLED_KB;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_kind        <= KIND_PORT_RD;
        i_port        <= '0;
        i_cpu_address <= '0;
        i_write_data  <= '0;
        i_out_stall   <= 1'b0;
        reset_mapper_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_memory();
        test_register_map();
        test_random_traffic(12'd4095, 1'b1, PACE_FREE, 180);
        test_random_traffic(12'd1024, 1'b0, PACE_SEND_IDLE, 170);
        test_random_traffic(12'd641, 1'b1, PACE_RECV_STALL, 170);
        test_random_traffic(12'd0, 1'b0, PACE_BOTH, 120);
        test_random_traffic(KB_W'($urandom_range(641, 4095)), 1'b0, PACE_BOTH, 170);
        test_random_traffic(KB_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                            PACE_FREE, 120);
        test_backpressure();

        wait_drained();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
